>>> hdl/bpe_pkg.sv
// Package for the Bezier point evaluation unit.
// Holds the default sizes, the configuration register indexes and their widths.
// No dependencies.
package bpe_pkg;

	localparam int MAX_DEGREE  = 3;
	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;

	localparam int DEGREE_W  = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_D = 3'd4;

endpackage

>>> hdl/bpe_level.sv
// One level of the exact de Casteljau recursion, split into a multiply stage and
// a sum stage with valid/ready flow control between them.
// Depends on bpe_pkg for default sizes and the degree width.
module bpe_level #(
	parameter int LEVEL       = 1,
	parameter int MAX_DEGREE  = bpe_pkg::MAX_DEGREE,
	parameter int COORD_BITS  = bpe_pkg::COORD_BITS,
	parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [T_FRAC_BITS:0] in_t,
	input  logic [T_FRAC_BITS:0] in_s,
	input  logic [bpe_pkg::DEGREE_W-1:0] in_deg,
	input  logic signed [COORD_BITS+MAX_DEGREE*T_FRAC_BITS-1:0] in_pts [MAX_DEGREE+1][3],
	output logic out_valid,
	input  logic out_ready,
	output logic [T_FRAC_BITS:0] out_t,
	output logic [T_FRAC_BITS:0] out_s,
	output logic [bpe_pkg::DEGREE_W-1:0] out_deg,
	output logic signed [COORD_BITS+MAX_DEGREE*T_FRAC_BITS-1:0] out_pts [MAX_DEGREE+1][3]
);

	localparam int W     = COORD_BITS + MAX_DEGREE * T_FRAC_BITS;
	localparam int IN_W  = COORD_BITS + (LEVEL - 1) * T_FRAC_BITS;
	localparam int OUT_W = IN_W + T_FRAC_BITS;
	localparam int LO_W  = IN_W / 2;
	localparam int HI_W  = IN_W - LO_W;
	localparam int PL_W  = LO_W + T_FRAC_BITS + 1;
	localparam int PH_W  = HI_W + T_FRAC_BITS + 2;
	localparam int NOUT  = MAX_DEGREE - LEVEL + 1;

	logic                   use_next;
	logic [PL_W-1:0]        pl_s_d [NOUT][3];
	logic [PL_W-1:0]        pl_t_d [NOUT][3];
	logic signed [PH_W-1:0] ph_s_d [NOUT][3];
	logic signed [PH_W-1:0] ph_t_d [NOUT][3];

	logic                   valid_s1;
	logic                   ready_s1;
	logic [T_FRAC_BITS:0]   t_s1;
	logic [T_FRAC_BITS:0]   s_s1;
	logic [bpe_pkg::DEGREE_W-1:0] deg_s1;
	logic [PL_W-1:0]        pl_s_s1 [NOUT][3];
	logic [PL_W-1:0]        pl_t_s1 [NOUT][3];
	logic signed [PH_W-1:0] ph_s_s1 [NOUT][3];
	logic signed [PH_W-1:0] ph_t_s1 [NOUT][3];

	logic                   valid_s2;
	logic                   ready_s2;
	logic [T_FRAC_BITS:0]   t_s2;
	logic [T_FRAC_BITS:0]   s_s2;
	logic [bpe_pkg::DEGREE_W-1:0] deg_s2;
	logic signed [OUT_W-1:0] sum_s2 [NOUT][3];

	// Beyond the curve's degree the level scales a point by one, so the
	// right neighbor is replaced by the point itself.
	assign use_next = (bpe_pkg::DEGREE_W'(LEVEL) <= in_deg);

	always_comb begin
		logic signed [IN_W-1:0] a_op;
		logic signed [IN_W-1:0] b_op;
		for (int i = 0; i < NOUT; i++) begin
			for (int a = 0; a < 3; a++) begin
				a_op = in_pts[i][a][IN_W-1:0];
				b_op = use_next ? in_pts[i+1][a][IN_W-1:0] : in_pts[i][a][IN_W-1:0];
				pl_s_d[i][a] = PL_W'(a_op[LO_W-1:0]) * PL_W'(in_s);
				pl_t_d[i][a] = PL_W'(b_op[LO_W-1:0]) * PL_W'(in_t);
				ph_s_d[i][a] = PH_W'($signed(a_op[IN_W-1:LO_W])) *
					PH_W'($signed({1'b0, in_s}));
				ph_t_d[i][a] = PH_W'($signed(b_op[IN_W-1:LO_W])) *
					PH_W'($signed({1'b0, in_t}));
			end
		end
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			t_s1    <= in_t;
			s_s1    <= in_s;
			deg_s1  <= in_deg;
			pl_s_s1 <= pl_s_d;
			pl_t_s1 <= pl_t_d;
			ph_s_s1 <= ph_s_d;
			ph_t_s1 <= ph_t_d;
		end
		if (valid_s1 && ready_s2) begin
			t_s2   <= t_s1;
			s_s2   <= s_s1;
			deg_s2 <= deg_s1;
			for (int i = 0; i < NOUT; i++) begin
				for (int a = 0; a < 3; a++) begin
					sum_s2[i][a] <= (OUT_W'(ph_s_s1[i][a]) << LO_W) + OUT_W'(pl_s_s1[i][a])
						+ (OUT_W'(ph_t_s1[i][a]) << LO_W) + OUT_W'(pl_t_s1[i][a]);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			for (int a = 0; a < 3; a++) begin
				if (i < NOUT) begin
					out_pts[i][a] = W'(sum_s2[i][a]);
				end else begin
					out_pts[i][a] = '0;
				end
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_t     = t_s2;
	assign out_s     = s_s2;
	assign out_deg   = deg_s2;

endmodule

>>> hdl/bezier_point_eval_unit.sv
// Bezier point evaluation unit, top level: configuration registers, input stage,
// the chain of recursion levels and the rounding output stage.
// Depends on bpe_pkg and bpe_level.
//
// Usage: the curve degree and the control points are written through the plain
// write port (wr_en, wr_index, wr_data) while no transaction is in flight. Each
// transaction on the t channel (t_param, t_valid, t_ready) yields exactly one
// transaction on the pos channel (pos_x, pos_y, pos_z, pos_valid, pos_ready).
// A t_param above one is taken as one. The point is the exact Bernstein sum,
// rounded to nearest with ties toward plus infinity, and saturated.
// The pipeline has one input stage, a multiply stage and a sum stage for each
// recursion level, and one rounding stage. Throughput is one transaction per
// cycle while the receiver does not stall; every stage holds one transaction.
// When the receiver stalls, each stage keeps its transaction and stages behind
// it still advance into empty slots, so t_ready falls only when the pipeline
// is full. Reset empties the pipeline, sets the degree to three and clears all
// control points to zero.
module bezier_point_eval_unit #(
	parameter int MAX_DEGREE  = bpe_pkg::MAX_DEGREE,
	parameter int COORD_BITS  = bpe_pkg::COORD_BITS,
	parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [bpe_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [3*COORD_BITS-1:0] wr_data,
	input  logic t_valid,
	output logic t_ready,
	input  logic [T_FRAC_BITS:0] t_param,
	output logic pos_valid,
	input  logic pos_ready,
	output logic signed [COORD_BITS-1:0] pos_x,
	output logic signed [COORD_BITS-1:0] pos_y,
	output logic signed [COORD_BITS-1:0] pos_z
);

	localparam int W    = COORD_BITS + MAX_DEGREE * T_FRAC_BITS;
	localparam int SH   = MAX_DEGREE * T_FRAC_BITS;
	localparam int RS_W = W + 1 - SH;
	localparam int DW   = bpe_pkg::DEGREE_W;
	localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
	localparam logic [W:0] HALF = (W+1)'(1) << (SH - 1);

	logic [DW-1:0]           degree_q;
	logic [3*COORD_BITS-1:0] points_q [MAX_DEGREE+1];
	logic [DW-1:0]           degree_eff;
	logic [T_FRAC_BITS:0]    t_clamp;

	logic                 valid_s1;
	logic [T_FRAC_BITS:0] t_s1;
	logic [T_FRAC_BITS:0] s_s1;
	logic [DW-1:0]        deg_s1;

	logic                    lv_valid [MAX_DEGREE+1];
	logic                    lv_ready [MAX_DEGREE+1];
	logic [T_FRAC_BITS:0]    lv_t     [MAX_DEGREE+1];
	logic [T_FRAC_BITS:0]    lv_s     [MAX_DEGREE+1];
	logic [DW-1:0]           lv_deg   [MAX_DEGREE+1];
	logic signed [W-1:0]     lv_pts   [MAX_DEGREE+1][MAX_DEGREE+1][3];

	logic                    valid_s2;
	logic                    ready_s2;
	logic signed [COORD_BITS-1:0] coord_d  [3];
	logic signed [COORD_BITS-1:0] coord_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= bpe_pkg::DEGREE_RESET;
			for (int p = 0; p <= MAX_DEGREE; p++) begin
				points_q[p] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == bpe_pkg::CFG_DEGREE) begin
				degree_q <= wr_data[DW-1:0];
			end
			for (int p = 0; p <= MAX_DEGREE; p++) begin
				if (wr_index == bpe_pkg::CFG_POINT_A + bpe_pkg::CFG_IDX_W'(p)) begin
					points_q[p] <= wr_data;
				end
			end
		end
	end

	assign degree_eff = (degree_q > DW'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : degree_q;
	assign t_clamp    = (t_param > T_ONE) ? T_ONE : t_param;

	assign t_ready = !valid_s1 || lv_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (t_ready) begin
			valid_s1 <= t_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (t_valid && t_ready) begin
			t_s1   <= t_clamp;
			s_s1   <= T_ONE - t_clamp;
			deg_s1 <= degree_eff;
		end
	end

	assign lv_valid[0] = valid_s1;
	assign lv_t[0]     = t_s1;
	assign lv_s[0]     = s_s1;
	assign lv_deg[0]   = deg_s1;

	always_comb begin
		for (int p = 0; p <= MAX_DEGREE; p++) begin
			for (int a = 0; a < 3; a++) begin
				lv_pts[0][p][a] = W'($signed(points_q[p][a*COORD_BITS +: COORD_BITS]));
			end
		end
	end

	for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_level
		bpe_level #(
			.LEVEL       (k),
			.MAX_DEGREE  (MAX_DEGREE),
			.COORD_BITS  (COORD_BITS),
			.T_FRAC_BITS (T_FRAC_BITS)
		) u_level (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lv_valid[k-1]),
			.in_ready  (lv_ready[k-1]),
			.in_t      (lv_t[k-1]),
			.in_s      (lv_s[k-1]),
			.in_deg    (lv_deg[k-1]),
			.in_pts    (lv_pts[k-1]),
			.out_valid (lv_valid[k]),
			.out_ready (lv_ready[k]),
			.out_t     (lv_t[k]),
			.out_s     (lv_s[k]),
			.out_deg   (lv_deg[k]),
			.out_pts   (lv_pts[k])
		);
	end

	// The final level holds the point scaled by one to the power MAX_DEGREE.
	always_comb begin
		logic signed [W:0]      rnd;
		logic signed [RS_W-1:0] shr;
		for (int a = 0; a < 3; a++) begin
			rnd = (W+1)'(lv_pts[MAX_DEGREE][0][a]) + $signed(HALF);
			shr = rnd[W:SH];
			if (shr[RS_W-1] != shr[RS_W-2]) begin
				coord_d[a] = shr[RS_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
					: {1'b0, {(COORD_BITS-1){1'b1}}};
			end else begin
				coord_d[a] = shr[COORD_BITS-1:0];
			end
		end
	end

	assign ready_s2            = !valid_s2 || pos_ready;
	assign lv_ready[MAX_DEGREE] = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= lv_valid[MAX_DEGREE];
		end
	end

	always_ff @(posedge clk) begin
		if (lv_valid[MAX_DEGREE] && ready_s2) begin
			coord_s2 <= coord_d;
		end
	end

	assign pos_valid = valid_s2;
	assign pos_x     = coord_s2[0];
	assign pos_y     = coord_s2[1];
	assign pos_z     = coord_s2[2];

endmodule

>>> sim/tb_bezier_point_eval_unit.sv
// Testbench for bezier_point_eval_unit: directed and random curve evaluations, checked
// against an exact de Casteljau predictor with 128-bit intermediate values.
// Depends on bpe_pkg and the RTL of bezier_point_eval_unit.
`timescale 1ns / 1ps

module tb_bezier_point_eval_unit;

	localparam int MAX_DEGREE  = bpe_pkg::MAX_DEGREE;
	localparam int COORD_BITS  = bpe_pkg::COORD_BITS;
	localparam int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS;
	localparam int DEGREE_W    = bpe_pkg::DEGREE_W;
	localparam int CFG_IDX_W   = bpe_pkg::CFG_IDX_W;

	localparam int PIPE_LATENCY = 2 * MAX_DEGREE + 2;
	localparam int POINT_W = 3 * COORD_BITS;
	localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
	localparam logic [T_FRAC_BITS:0] T_MAX = '1;

	typedef logic signed [127:0] acc_t;
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [POINT_W-1:0] wr_data = '0;
	logic t_valid = 1'b0;
	logic t_ready;
	logic [T_FRAC_BITS:0] t_param = '0;
	logic pos_valid;
	logic pos_ready = 1'b0;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;

	logic [DEGREE_W-1:0] cur_degree = bpe_pkg::DEGREE_RESET;
	logic [POINT_W-1:0] cur_pts [MAX_DEGREE+1] = '{default: '0};
	pos_t pending_pos_q [$];
	pos_t pos_head;
	int mismatch_count = 0;
	bit idle_en = 1'b1;
	int rx_hold_cycles = 0;

	bezier_point_eval_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.t_valid(t_valid),
		.t_ready(t_ready),
		.t_param(t_param),
		.pos_valid(pos_valid),
		.pos_ready(pos_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic signed [COORD_BITS-1:0] bezier_axis(int n, logic [T_FRAC_BITS:0] t,
			int axis);
		acc_t q [MAX_DEGREE+1];
		acc_t tw;
		acc_t sw;
		acc_t r;
		acc_t vmax;
		acc_t vmin;
		logic signed [COORD_BITS-1:0] c;
		int sh;
		for (int i = 0; i <= n; i++) begin
			c = cur_pts[i][axis*COORD_BITS +: COORD_BITS];
			q[i] = acc_t'(c);
		end
		tw = acc_t'({1'b0, t});
		sw = (acc_t'(1) <<< T_FRAC_BITS) - tw;
		for (int lvl = 1; lvl <= n; lvl++) begin
			for (int i = 0; i + lvl <= n; i++) begin
				q[i] = q[i] * sw + q[i+1] * tw;
			end
		end
		sh = n * T_FRAC_BITS;
		if (sh > 0) begin
			r = (q[0] + (acc_t'(1) <<< (sh - 1))) >>> sh;
		end else begin
			r = q[0];
		end
		vmax = (acc_t'(1) <<< (COORD_BITS - 1)) - 1;
		vmin = -vmax - 1;
		if (r > vmax) begin
			r = vmax;
		end
		if (r < vmin) begin
			r = vmin;
		end
		return r[COORD_BITS-1:0];
	endfunction

	function automatic pos_t bezier_point(logic [T_FRAC_BITS:0] t_in);
		pos_t p;
		int n;
		logic [T_FRAC_BITS:0] t;
		n = int'(cur_degree);
		if (n > MAX_DEGREE) begin
			n = MAX_DEGREE;
		end
		t = (t_in > T_ONE) ? T_ONE : t_in;
		p.x = bezier_axis(n, t, 0);
		p.y = bezier_axis(n, t, 1);
		p.z = bezier_axis(n, t, 2);
		return p;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(COORD_BITS-1){1'b0}}};
			1: return {1'b0, {(COORD_BITS-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [POINT_W-1:0] pick_point();
		return {pick_coord(), pick_coord(), pick_coord()};
	endfunction

	function automatic logic [T_FRAC_BITS:0] pick_t();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return T_ONE;
			2: return (T_FRAC_BITS+1)'($urandom_range(int'(T_ONE) + 1, int'(T_MAX)));
			3: return (T_FRAC_BITS+1)'($urandom_range(0, 15));
			4: return (T_FRAC_BITS+1)'($urandom_range(int'(T_ONE) - 15, int'(T_ONE)));
			default: return (T_FRAC_BITS+1)'($urandom_range(0, int'(T_ONE)));
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POINT_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			bpe_pkg::CFG_DEGREE: cur_degree = data[DEGREE_W-1:0];
			bpe_pkg::CFG_POINT_A: cur_pts[0] = data;
			bpe_pkg::CFG_POINT_B: cur_pts[1] = data;
			bpe_pkg::CFG_POINT_C: cur_pts[2] = data;
			bpe_pkg::CFG_POINT_D: cur_pts[3] = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_degree(int deg);
		logic [POINT_W-1:0] data;
		data = {16'($urandom), 32'($urandom)};
		data[DEGREE_W-1:0] = DEGREE_W'(deg);
		write_reg(bpe_pkg::CFG_DEGREE, data);
	endtask

	task automatic write_points(logic [POINT_W-1:0] a, logic [POINT_W-1:0] b,
			logic [POINT_W-1:0] c, logic [POINT_W-1:0] d);
		write_reg(bpe_pkg::CFG_POINT_A, a);
		write_reg(bpe_pkg::CFG_POINT_B, b);
		write_reg(bpe_pkg::CFG_POINT_C, c);
		write_reg(bpe_pkg::CFG_POINT_D, d);
	endtask

	task automatic send_t(logic [T_FRAC_BITS:0] t);
		int gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
		end
		if (gap > 0) begin
			t_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t_valid <= 1'b1;
		t_param <= t;
		do begin
			@(posedge clk);
		end while (!t_ready);
		pending_pos_q = {pending_pos_q, bezier_point(t)};
	endtask

	task automatic wait_drain();
		t_valid <= 1'b0;
		while (pending_pos_q.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				pos_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
				pos_ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				pos_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				pos_ready <= 1'b1;
			end else begin
				pos_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pos_valid && pos_ready) begin
			if (pending_pos_q.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("Unexpected pos transaction: x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z);
				end
				mismatch_count++;
			end else begin
				pos_head = pending_pos_q.pop_front();
				if (pos_x !== pos_head.x || pos_y !== pos_head.y || pos_z !== pos_head.z) begin
					if (mismatch_count < 10) begin
						$display("Mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
							pos_head.x, pos_head.y, pos_head.z, pos_x, pos_y, pos_z);
					end
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_reset_state();
		send_t('0);
		send_t(T_ONE >> 1);
		send_t(T_ONE);
		wait_drain();
	endtask

	task automatic test_extreme_points();
		write_degree(3);
		write_points(48'h7FFF_8000_8000, 48'h8000_7FFF_7FFF, 48'h7FFF_8000_7FFF,
			48'h8000_7FFF_8000);
		send_t('0);
		send_t((T_FRAC_BITS+1)'(1));
		send_t(T_ONE >> 1);
		send_t(T_ONE - (T_FRAC_BITS+1)'(1));
		send_t(T_ONE);
		send_t(T_MAX);
		wait_drain();
	endtask

	task automatic test_degrees_and_ties();
		write_degree(0);
		send_t((T_FRAC_BITS+1)'(12345));
		send_t(T_MAX);
		wait_drain();
		write_degree(1);
		write_points(48'h0000_0000_0000, 48'h0003_FFFF_0001, pick_point(), pick_point());
		send_t(T_ONE >> 1);
		send_t(T_ONE + (T_FRAC_BITS+1)'(1));
		wait_drain();
		write_degree(2);
		write_reg(bpe_pkg::CFG_POINT_C, 48'hFFFD_0002_0001);
		send_t(T_ONE >> 1);
		send_t(T_ONE >> 2);
		wait_drain();
	endtask

	task automatic test_ignored_writes();
		write_reg(CFG_IDX_W'(5), {16'($urandom), 32'($urandom)});
		write_reg(CFG_IDX_W'(6), {16'($urandom), 32'($urandom)});
		write_reg(CFG_IDX_W'(7), {16'($urandom), 32'($urandom)});
		send_t(T_ONE >> 1);
		send_t(T_ONE);
		wait_drain();
	endtask

	task automatic random_phase(int deg, int count, bit pause_mid);
		write_degree(deg);
		write_points(pick_point(), pick_point(), pick_point(), pick_point());
		if ($urandom_range(0, 2) == 0) begin
			write_reg(CFG_IDX_W'($urandom_range(5, 7)), {16'($urandom), 32'($urandom)});
		end
		for (int i = 0; i < count; i++) begin
			send_t(pick_t());
			if (pause_mid && i == count / 2) begin
				wait_drain();
			end
		end
		wait_drain();
	endtask

	task automatic test_random_curves();
		for (int ph = 0; ph < 8; ph++) begin
			idle_en = (ph != 5);
			random_phase((ph < 4) ? ph : $urandom_range(0, 3), 90, ph == 2);
		end
		idle_en = 1'b1;
	endtask

	task automatic test_output_stall();
		idle_en = 1'b0;
		write_degree(3);
		write_points(pick_point(), pick_point(), pick_point(), pick_point());
		rx_hold_cycles = 80;
		for (int i = 0; i < 40; i++) begin
			send_t(pick_t());
		end
		wait_drain();
		idle_en = 1'b1;
	endtask

	task automatic test_no_idle();
		idle_en = 1'b0;
		random_phase(3, 60, 1'b0);
		random_phase($urandom_range(0, 3), 40, 1'b0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_extreme_points();
		test_degrees_and_ties();
		test_ignored_writes();
		test_random_curves();
		test_output_stall();
		test_no_idle();
		wait_drain();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (mismatch_count == 0 && pending_pos_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> bezier_point_eval_unit.f
hdl/bpe_pkg.sv
hdl/bpe_level.sv
hdl/bezier_point_eval_unit.sv
sim/tb_bezier_point_eval_unit.sv
